@@ sv/lfp_pkg.sv @@
package lfp_pkg;

	// command codes of an input word
	localparam logic CMD_HEADER  = 1'b0;
	localparam logic CMD_PAYLOAD = 1'b1;

	// configuration register indexes
	localparam logic REG_SYNC_FIRST  = 1'b0;
	localparam logic REG_SYNC_SECOND = 1'b1;

	localparam logic [7:0] SYNC_FIRST_RESET  = 8'd188;
	localparam logic [7:0] SYNC_SECOND_RESET = 8'd207;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic [2:0] {
		JOB_HDR,       // start bytes, type, length
		JOB_HDR_END,   // zero-length frame: header plus both sums
		JOB_ERR,       // rejected header
		JOB_DATA,      // one payload byte
		JOB_DATA_END   // last payload byte plus both sums
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] byte_a;   // type or payload byte
		logic [7:0] byte_b;   // length
		logic [7:0] sum_a;
		logic [7:0] sum_b;
	} job_t;

endpackage

@@ sv/lfp_if.sv @@
interface lfp_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] pkt_type;
	logic [7:0] pkt_length;
	logic [7:0] payload_byte;

	modport source (output valid, command, pkt_type, pkt_length, payload_byte, input ready);
	modport sink   (input valid, command, pkt_type, pkt_length, payload_byte, output ready);
endinterface

interface lfp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;
	logic       length_error;

	modport source (output valid, frame_byte, frame_end, length_error, input ready);
	modport sink   (input valid, frame_byte, frame_end, length_error, output ready);
endinterface

@@ sv/lfp_front.sv @@
module lfp_front
	import lfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	lfp_in_if.sink         item,
	input  logic           q_full,
	output logic           q_push,
	output job_t           q_job
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	logic [7:0] sum_low_q;
	logic [7:0] sum_high_q;
	logic [7:0] bytes_left_q;
	logic       open_q;

	logic       accept;
	logic [7:0] hdr_a;
	logic [7:0] hdr_b;
	logic [7:0] pay_a;
	logic [7:0] pay_b;

	assign item.ready = !q_full;
	assign accept     = item.valid && item.ready;

	// sums after type and length
	assign hdr_a = item.pkt_type + item.pkt_length;
	assign hdr_b = item.pkt_type + hdr_a;
	// sums after one payload byte
	assign pay_a = sum_low_q + item.payload_byte;
	assign pay_b = sum_high_q + pay_a;

	always_comb begin
		q_push        = 1'b0;
		q_job.kind    = JOB_DATA;
		q_job.byte_a  = item.payload_byte;
		q_job.byte_b  = item.pkt_length;
		q_job.sum_a   = pay_a;
		q_job.sum_b   = pay_b;
		if (accept) begin
			if (item.command == CMD_HEADER) begin
				q_push       = 1'b1;
				q_job.byte_a = item.pkt_type;
				q_job.sum_a  = hdr_a;
				q_job.sum_b  = hdr_b;
				priority if (item.pkt_length > MAX_LEN) begin
					q_job.kind = JOB_ERR;
				end else if (item.pkt_length == 8'd0) begin
					q_job.kind = JOB_HDR_END;
				end else begin
					q_job.kind = JOB_HDR;
				end
			end else if (open_q) begin
				q_push     = 1'b1;
				q_job.kind = (bytes_left_q == 8'd1) ? JOB_DATA_END : JOB_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q    <= '0;
			sum_high_q   <= '0;
			bytes_left_q <= '0;
			open_q       <= 1'b0;
		end else if (accept) begin
			if (item.command == CMD_HEADER) begin
				if (item.pkt_length > MAX_LEN || item.pkt_length == 8'd0) begin
					sum_low_q    <= '0;
					sum_high_q   <= '0;
					bytes_left_q <= '0;
					open_q       <= 1'b0;
				end else begin
					sum_low_q    <= hdr_a;
					sum_high_q   <= hdr_b;
					bytes_left_q <= item.pkt_length;
					open_q       <= 1'b1;
				end
			end else if (open_q) begin
				bytes_left_q <= bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					sum_low_q  <= '0;
					sum_high_q <= '0;
					open_q     <= 1'b0;
				end else begin
					sum_low_q  <= pay_a;
					sum_high_q <= pay_b;
				end
			end
		end
	end

endmodule

@@ sv/lfp_queue.sv @@
module lfp_queue
	import lfp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == DEPTH_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/lfp_back.sv @@
module lfp_back
	import lfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       q_empty,
	output logic       q_pop,
	input  logic [7:0] sync_first,
	input  logic [7:0] sync_second,
	lfp_out_if.source  frame
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       end_q;
	logic       err_q;

	logic       load;
	logic [2:0] last_idx;
	logic [7:0] nxt_byte;
	logic       nxt_end;
	logic       nxt_err;

	assign frame.valid        = valid_q;
	assign frame.frame_byte   = byte_q;
	assign frame.frame_end    = end_q;
	assign frame.length_error = err_q;

	assign load  = !q_empty && (!valid_q || frame.ready);
	assign q_pop = load && (idx_q == last_idx);

	always_comb begin
		nxt_byte = 8'd0;
		nxt_end  = 1'b0;
		nxt_err  = 1'b0;
		last_idx = 3'd0;
		unique case (head.kind)
			JOB_HDR, JOB_HDR_END: begin
				last_idx = (head.kind == JOB_HDR) ? 3'd3 : 3'd5;
				unique case (idx_q)
					3'd0:    nxt_byte = sync_first;
					3'd1:    nxt_byte = sync_second;
					3'd2:    nxt_byte = head.byte_a;
					3'd3:    nxt_byte = head.byte_b;
					3'd4:    nxt_byte = head.sum_a;
					default: begin
						nxt_byte = head.sum_b;
						nxt_end  = 1'b1;
					end
				endcase
			end
			JOB_ERR: begin
				nxt_err = 1'b1;
			end
			JOB_DATA: begin
				nxt_byte = head.byte_a;
			end
			JOB_DATA_END: begin
				last_idx = 3'd2;
				unique case (idx_q)
					3'd0:    nxt_byte = head.byte_a;
					3'd1:    nxt_byte = head.sum_a;
					default: begin
						nxt_byte = head.sum_b;
						nxt_end  = 1'b1;
					end
				endcase
			end
			default: begin
				nxt_byte = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= q_pop ? 3'd0 : idx_q + 3'd1;
			end else if (frame.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= nxt_byte;
			end_q  <= nxt_end;
			err_q  <= nxt_err;
		end
	end

endmodule

@@ sv/link_packet_framer_fletcher8.sv @@
// path: an accepted word is written into the job queue, and the back loads its first frame
// byte from the queue head into the output register, where the receiver can take it
// throughput: one input word per cycle while the job queue has room; one frame byte per
// cycle out while the receiver is ready, so payloads run at full rate and header/tail
// bursts sit in the four-entry job queue (a header is four or six bytes, last byte three)
// reset: arst_n asynchronous active low; clears the sums, the open-packet state,
// the queue and the output valid, and loads the start bytes 188 and 207
module link_packet_framer_fletcher8
	import lfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	lfp_in_if.sink     item,
	lfp_out_if.source  frame,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);

	// start-of-frame bytes; the user must write them only while the framer is idle, the block does not enforce it
	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;

	// front to queue
	logic q_push;
	job_t q_job;
	logic q_full;

	// queue to back
	job_t q_head;
	logic q_empty;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RESET;
			sync_second_q <= SYNC_SECOND_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_wdata;
				REG_SYNC_SECOND: sync_second_q <= cfg_wdata;
				default:         sync_first_q  <= sync_first_q;
			endcase
		end
	end

	// front: tracks the open packet and the running sums, turns each header
	// and each payload word of an open packet into one job describing the bytes it produces
	lfp_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (q_job)
	);

	// short job queue decoupling input from output stalls
	lfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// back: walks each job one frame byte per cycle into the output register while the receiver is ready
	lfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.frame       (frame)
	);

`ifndef SYNTHESIS
	// a rejected header carries a zero byte and never closes a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.length_error |-> frame.frame_byte == 8'd0 && !frame.frame_end)
		else $error("error word malformed");

	// input stalls only when the job queue is full
	assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> q_full)
		else $error("input stalled with room in queue");

	// the back never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty job queue");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// one expected word on the frame channel
typedef struct {
	logic [7:0] frame_byte;
	logic       frame_end;
	logic       length_error;
} frame_word_t;

class frame_scoreboard;
	frame_word_t pending[$];
	logic [7:0]  sync_first;
	logic [7:0]  sync_second;
	logic [7:0]  sum_a;
	logic [7:0]  sum_b;
	logic [7:0]  bytes_left;
	bit          packet_open;
	int          max_len;
	int          failures;
	int          checked;
	int          frames;
	int          rejected;

	function new(int mtu);
		max_len     = mtu;
		sync_first  = lfp_pkg::SYNC_FIRST_RESET;
		sync_second = lfp_pkg::SYNC_SECOND_RESET;
		sum_a       = 8'd0;
		sum_b       = 8'd0;
		bytes_left  = 8'd0;
		packet_open = 1'b0;
	endfunction

	function void set_sync(logic index, logic [7:0] value);
		if (index == lfp_pkg::REG_SYNC_FIRST) sync_first = value;
		else sync_second = value;
	endfunction

	function void push_word(logic [7:0] b, logic e, logic r);
		frame_word_t w;
		w.frame_byte   = b;
		w.frame_end    = e;
		w.length_error = r;
		pending.push_back(w);
	endfunction

	// fletcher step: b runs over the successive values of a
	function void fold(logic [7:0] b);
		sum_a = sum_a + b;
		sum_b = sum_b + sum_a;
	endfunction

	function void close_frame();
		push_word(sum_a, 1'b0, 1'b0);
		push_word(sum_b, 1'b1, 1'b0);
		sum_a = 8'd0;
		sum_b = 8'd0;
		packet_open = 1'b0;
	endfunction

	function void note_word(logic command, logic [7:0] pkt_type, logic [7:0] pkt_length,
			logic [7:0] payload_byte);
		if (command == lfp_pkg::CMD_HEADER) begin
			// a header always drops whatever packet was open
			packet_open = 1'b0;
			bytes_left  = 8'd0;
			sum_a       = 8'd0;
			sum_b       = 8'd0;
			if (pkt_length > max_len) begin
				push_word(8'd0, 1'b0, 1'b1);
				rejected++;
				return;
			end
			push_word(sync_first, 1'b0, 1'b0);
			push_word(sync_second, 1'b0, 1'b0);
			push_word(pkt_type, 1'b0, 1'b0);
			push_word(pkt_length, 1'b0, 1'b0);
			fold(pkt_type);
			fold(pkt_length);
			if (pkt_length == 8'd0) begin
				close_frame();
			end else begin
				bytes_left  = pkt_length;
				packet_open = 1'b1;
			end
		end else if (packet_open) begin
			fold(payload_byte);
			push_word(payload_byte, 1'b0, 1'b0);
			bytes_left = bytes_left - 8'd1;
			if (bytes_left == 8'd0) close_frame();
		end
	endfunction

	function void check_word(logic [7:0] got_byte, logic got_end, logic got_err);
		frame_word_t want;
		if (pending.size() == 0) begin
			$error("unexpected frame word: frame_byte %0d frame_end %0d length_error %0d",
				got_byte, got_end, got_err);
			failures++;
			return;
		end
		want = pending.pop_front();
		checked++;
		if (got_end === 1'b1) frames++;
		if (got_byte !== want.frame_byte) begin
			$error("frame_byte: expected %0d, got %0d", want.frame_byte, got_byte);
			failures++;
		end
		if (got_end !== want.frame_end) begin
			$error("frame_end: expected %0d, got %0d", want.frame_end, got_end);
			failures++;
		end
		if (got_err !== want.length_error) begin
			$error("length_error: expected %0d, got %0d", want.length_error, got_err);
			failures++;
		end
	endfunction
endclass

module testbench;
	import lfp_pkg::*;

	localparam int MAX_LEN     = 64;
	localparam int CYCLE_LIMIT = 600000;   // far above the slowest legal run
	localparam int SETTLE      = 8;        // well above the input-to-output latency

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_wdata;

	lfp_in_if  item_if();
	lfp_out_if frame_if();

	link_packet_framer_fletcher8 #(
		.MAX_PAYLOAD(MAX_LEN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_if),
		.frame    (frame_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	frame_scoreboard book;

	int cycles;
	int words_sent;
	int in_count;
	int out_count;
	int in_mode;     // idle style of the sender, redrawn every few dozen words
	int out_mode;    // idle style of the receiver
	int settings;

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// mode 0: no idling at all, 1: full 0..16 range, 2: mostly back to back
	function automatic int draw_wait(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 16);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		endcase
	endfunction

	// hand one word to the block; returns at the edge where it was taken
	task automatic send_word(input logic cmd, input logic [7:0] typ, input logic [7:0] len,
			input logic [7:0] data);
		int gap;
		in_count++;
		if (in_count % 40 == 0) in_mode = $urandom_range(0, 2);
		gap = draw_wait(in_mode);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid        <= 1'b1;
		item_if.command      <= cmd;
		item_if.pkt_type     <= typ;
		item_if.pkt_length   <= len;
		item_if.payload_byte <= data;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		book.note_word(cmd, typ, len, data);
		words_sent++;
	endtask

	// fields a command does not read get random junk
	task automatic send_header(input logic [7:0] typ, input logic [7:0] len);
		send_word(CMD_HEADER, typ, len, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_payload(input logic [7:0] data);
		send_word(CMD_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), data);
	endtask

	// drop valid, wait for every expected frame word, then let the pipe empty
	task automatic settle();
		item_if.valid <= 1'b0;
		while (book.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// both start bytes, one per edge, with the write enable held across
	task automatic write_sync_bytes(input logic [7:0] first, input logic [7:0] second);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SYNC_FIRST;
		cfg_wdata <= first;
		@(posedge clk);
		cfg_index <= REG_SYNC_SECOND;
		cfg_wdata <= second;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.set_sync(REG_SYNC_FIRST, first);
		book.set_sync(REG_SYNC_SECOND, second);
		settings++;
	endtask

	// mostly complete packets with random content; some oversize headers,
	// some abandoned packets and stray payload words between packets
	task automatic send_random_traffic(input int budget);
		int sent;
		int len;
		int keep;
		int pick;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) len = 0;
			else if (pick == 1) len = MAX_LEN;
			else if (pick == 2) len = $urandom_range(MAX_LEN + 1, 255);
			else if (pick <= 5) len = $urandom_range(9, MAX_LEN - 1);
			else len = $urandom_range(1, 8);
			send_header(8'($urandom_range(0, 255)), 8'(len));
			sent++;
			keep = 0;
			if (len > 0 && len <= MAX_LEN) begin
				keep = len;
				// cut the packet short so the next header abandons it
				if ($urandom_range(0, 11) == 0) keep = $urandom_range(0, len - 1);
				repeat (keep) begin
					send_payload(8'($urandom_range(0, 255)));
					sent++;
				end
			end
			// stray payload only while no packet is open
			if (keep == len || len > MAX_LEN) begin
				if ($urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(1, 3)) send_payload(8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	// receiver: random stalls, check every word taken
	initial begin
		int stall;
		frame_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			out_count++;
			if (out_count % 40 == 0) out_mode = $urandom_range(0, 2);
			stall = draw_wait(out_mode);
			if (stall > 0) begin
				frame_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			frame_if.ready <= 1'b1;
			@(posedge clk);
			while (!frame_if.valid) @(posedge clk);
			book.check_word(frame_if.frame_byte, frame_if.frame_end, frame_if.length_error);
		end
	end

	initial begin
		book       = new(MAX_LEN);
		words_sent = 0;
		in_count   = 0;
		out_count  = 0;
		in_mode    = 1;
		out_mode   = 1;
		settings   = 0;

		// known values on every input from time zero
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_SYNC_FIRST;
		cfg_wdata            = 8'd0;
		item_if.valid        = 1'b0;
		item_if.command      = CMD_HEADER;
		item_if.pkt_type     = 8'd0;
		item_if.pkt_length   = 8'd0;
		item_if.payload_byte = 8'd0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, start bytes at their reset values
		send_header(8'h00, 8'd0);            // zero-length frame, sums zero
		send_header(8'hFF, 8'd0);            // zero-length frame, sums wrap
		send_payload(8'h3C);                 // no packet open: ignored
		send_header(8'h12, 8'(MAX_LEN + 1)); // just over the limit
		send_header(8'hFF, 8'hFF);           // largest length, rejected
		send_header(8'hA5, 8'd3);            // full packet, extreme payload values
		send_payload(8'h00);
		send_payload(8'hFF);
		send_payload(8'h5A);
		send_header(8'hFF, 8'd1);            // shortest packet with payload
		send_payload(8'hFF);
		send_header(8'h01, 8'd5);            // opened, then abandoned after two words
		send_payload(8'h11);
		send_payload(8'h22);
		send_header(8'h7E, 8'd2);            // header while a packet is open
		send_payload(8'h80);
		send_payload(8'h01);
		send_payload(8'hC3);                 // stray after the frame closed
		settle();

		// random part under several start-byte settings, extremes first
		write_sync_bytes(8'h00, 8'hFF);
		send_random_traffic(135);
		settle();
		write_sync_bytes(8'hFF, 8'h00);
		send_random_traffic(135);
		settle();
		write_sync_bytes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		send_random_traffic(135);
		settle();

		if (book.pending.size() != 0) begin
			$error("%0d expected frame words never arrived", book.pending.size());
		end
		$display("run: %0d input words sent, %0d frame words checked", words_sent, book.checked);
		$display("run: %0d frames closed, %0d headers rejected, %0d start-byte settings written",
			book.frames, book.rejected, settings);
		if (book.failures == 0 && book.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
